/* rtl/core/rrps_pkg.sv */
// Shared types, codes and sizes of the round-robin process scheduler.
package rrps_pkg;

	localparam int MAX_PROCS = 8;
	localparam int ID_W      = 4;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int QUANTUM_W = 8;
	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd10;

	typedef logic [ID_W-1:0]  pid_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_BLOCK  = 3'd1;
	localparam logic [2:0] REQ_RESUME = 3'd2;
	localparam logic [2:0] REQ_TICK   = 3'd3;
	localparam logic [2:0] REQ_YIELD  = 3'd4;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
	localparam logic [1:0] STATUS_BAD_PID = 2'd2;

	typedef enum logic [1:0] {
		SLOT_UNUSED   = 2'd0,
		SLOT_RUNNABLE = 2'd1,
		SLOT_BLOCKED  = 2'd2
	} slot_st_t;

	typedef struct packed {
		logic [2:0] req_type;
		pid_t       target_pid;
	} req_t;

	typedef struct packed {
		pid_t       running_pid;
		logic       switched;
		pid_t       new_pid;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic pop;
		logic push;
		pid_t push_id;
	} q_ctrl_t;

	typedef struct packed {
		logic empty;
		pid_t head_id;
	} q_stat_t;

endpackage

/* rtl/core/round_robin_process_scheduler.sv */
// Top level of the round-robin process scheduler with time quantum.
// A request is taken when start is high and busy is low, and its one result is
// shown on result with done high for exactly one cycle, the first cycle in which busy
// is low again; the receiver cannot stall it. A request of unknown type goes straight to
// the done state; block and resume pass through the check state, yield through the pick
// state, and a tick through the tick state and, if it preempts, the pick state. A create
// examines slots from the lowest up, one slot per cycle through the single slot-table
// read port, until it finds a free slot or has examined the last. A new request can be
// taken in the same cycle as the previous result is shown. The quantum register is to be
// written with cfg_we and cfg_wdata while the block is idle; the block does not enforce it.
module round_robin_process_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  rrps_pkg::req_t                 req,
	input  logic                           cfg_we,
	input  logic [rrps_pkg::QUANTUM_W-1:0] cfg_wdata,
	output logic                           done,
	output rrps_pkg::result_t              result
);
	import rrps_pkg::*;

	logic [QUANTUM_W-1:0] quantum_q;
	logic                 done_q;
	result_t              result_q;
	q_ctrl_t              qctrl;
	q_stat_t              qstat;
	logic                 fin;
	result_t              fin_res;

	rrps_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.quantum (quantum_q),
		.qctrl   (qctrl),
		.qstat   (qstat),
		.fin     (fin),
		.fin_res (fin_res)
	);

	rrps_run_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qctrl),
		.stat   (qstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= fin_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe held for more than one cycle.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Block not busy after taking a request.");

	a_new_pid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.new_pid != '0) |-> result.status == STATUS_OK)
		else $error("New process id reported with a failing status.");
`endif

endmodule

/* rtl/core/rrps_run_queue.sv */
// Run queue of process ids with a queued mark per slot.
module rrps_run_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  rrps_pkg::q_ctrl_t ctrl,
	output rrps_pkg::q_stat_t stat
);
	import rrps_pkg::*;

	pid_t                 mem [MAX_PROCS];
	pid_t                 rd_q;
	idx_t                 head_q;
	logic [CNT_W-1:0]     count_q;
	logic [MAX_PROCS-1:0] mark_q;

	pid_t             push_m1;
	pid_t             pop_m1;
	idx_t             push_idx;
	idx_t             pop_idx;
	logic             push_id_ok;
	logic             pop_id_ok;
	logic             full;
	logic             push_ok;
	logic [IDX_W:0]   wr_sum;
	idx_t             wr_addr;
	idx_t             head_inc;

	always_comb begin
		push_m1    = ctrl.push_id - ID_W'(1);
		pop_m1     = rd_q - ID_W'(1);
		push_idx   = push_m1[IDX_W-1:0];
		pop_idx    = pop_m1[IDX_W-1:0];
		push_id_ok = (ctrl.push_id != '0) && (ctrl.push_id <= ID_W'(MAX_PROCS));
		pop_id_ok  = (rd_q != '0) && (rd_q <= ID_W'(MAX_PROCS));
		full       = (count_q == CNT_W'(MAX_PROCS)) && !ctrl.pop;
		push_ok    = ctrl.push && push_id_ok && !mark_q[push_idx] && !full;
		wr_sum     = {1'b0, head_q} + (IDX_W + 1)'(count_q);
		if (wr_sum >= (IDX_W + 1)'(MAX_PROCS)) begin
			wr_sum = wr_sum - (IDX_W + 1)'(MAX_PROCS);
		end
		wr_addr  = wr_sum[IDX_W-1:0];
		head_inc = (head_q == IDX_W'(MAX_PROCS - 1)) ? '0 : head_q + IDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_addr] <= ctrl.push_id;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			mark_q  <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q <= head_inc;
				if (pop_id_ok) begin
					mark_q[pop_idx] <= 1'b0;
				end
			end
			if (push_ok) begin
				mark_q[push_idx] <= 1'b1;
			end
			if (push_ok && !ctrl.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push_ok && ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign stat.empty   = (count_q == '0);
	assign stat.head_id = rd_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PROCS))
		else $error("Run queue count exceeds its depth.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> count_q != '0)
		else $error("Run queue popped while empty.");
`endif

endmodule

/* rtl/core/rrps_seq.sv */
// Request sequencer with the slot table and its shared slot examine unit.
module rrps_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  rrps_pkg::req_t                   req,
	input  logic [rrps_pkg::QUANTUM_W-1:0]   quantum,
	output rrps_pkg::q_ctrl_t                qctrl,
	input  rrps_pkg::q_stat_t                qstat,
	output logic                             fin,
	output rrps_pkg::result_t                fin_res
);
	import rrps_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_CHECK = 6'b000100,
		S_TICK  = 6'b001000,
		S_PICK  = 6'b010000,
		S_DONE  = 6'b100000
	} seq_state_t;

	seq_state_t           state_q;
	slot_st_t             slot_q [MAX_PROCS];
	logic [2:0]           req_type_q;
	pid_t                 target_q;
	pid_t                 before_q;
	pid_t                 cur_q;
	pid_t                 new_pid_q;
	logic [1:0]           status_q;
	logic [QUANTUM_W-1:0] ticks_q;
	idx_t                 idx_q;

	pid_t     tgt_m1;
	pid_t     cur_m1;
	idx_t     exam_idx;
	slot_st_t exam_st;
	pid_t     scan_id;
	logic     tgt_ok;
	logic     cur_runnable;
	pid_t     next_pid;

	always_comb begin
		tgt_m1  = target_q - ID_W'(1);
		cur_m1  = cur_q - ID_W'(1);
		scan_id = ID_W'(idx_q) + ID_W'(1);
		if (state_q == S_SCAN) begin
			exam_idx = idx_q;
		end else if (state_q == S_PICK) begin
			exam_idx = cur_m1[IDX_W-1:0];
		end else begin
			exam_idx = tgt_m1[IDX_W-1:0];
		end
		exam_st      = slot_q[exam_idx];
		tgt_ok       = (target_q != '0) && (target_q <= ID_W'(MAX_PROCS))
			&& (exam_st != SLOT_UNUSED);
		cur_runnable = (cur_q != '0) && (exam_st == SLOT_RUNNABLE);
		if (!qstat.empty) begin
			next_pid = qstat.head_id;
		end else if (cur_runnable) begin
			next_pid = cur_q;
		end else begin
			next_pid = '0;
		end

		qctrl = '0;
		unique case (state_q)
			S_SCAN: begin
				qctrl.push    = (exam_st == SLOT_UNUSED);
				qctrl.push_id = scan_id;
			end
			S_CHECK: begin
				qctrl.push    = tgt_ok && (req_type_q == REQ_RESUME);
				qctrl.push_id = target_q;
			end
			S_PICK: begin
				qctrl.pop     = !qstat.empty;
				qctrl.push    = (next_pid != cur_q) && cur_runnable;
				qctrl.push_id = cur_q;
			end
			default: begin
				qctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			slot_q     <= '{default: SLOT_UNUSED};
			req_type_q <= '0;
			target_q   <= '0;
			before_q   <= '0;
			cur_q      <= '0;
			new_pid_q  <= '0;
			status_q   <= STATUS_OK;
			ticks_q    <= '0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_type_q <= req.req_type;
						target_q   <= req.target_pid;
						before_q   <= cur_q;
						new_pid_q  <= '0;
						status_q   <= STATUS_OK;
						idx_q      <= '0;
						unique case (req.req_type)
							REQ_CREATE: state_q <= S_SCAN;
							REQ_BLOCK:  state_q <= S_CHECK;
							REQ_RESUME: state_q <= S_CHECK;
							REQ_TICK:   state_q <= S_TICK;
							REQ_YIELD:  state_q <= S_PICK;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (exam_st == SLOT_UNUSED) begin
						slot_q[idx_q] <= SLOT_RUNNABLE;
						new_pid_q     <= scan_id;
						state_q       <= S_DONE;
					end else if (idx_q == IDX_W'(MAX_PROCS - 1)) begin
						status_q <= STATUS_NO_SLOT;
						state_q  <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_CHECK: begin
					if (!tgt_ok) begin
						status_q <= STATUS_BAD_PID;
					end else if (req_type_q == REQ_BLOCK) begin
						slot_q[exam_idx] <= SLOT_BLOCKED;
					end else begin
						slot_q[exam_idx] <= SLOT_RUNNABLE;
					end
					state_q <= S_DONE;
				end
				S_TICK: begin
					if (cur_q == '0) begin
						state_q <= S_DONE;
					end else if (ticks_q <= QUANTUM_W'(1)) begin
						ticks_q <= quantum;
						state_q <= S_PICK;
					end else begin
						ticks_q <= ticks_q - QUANTUM_W'(1);
						state_q <= S_DONE;
					end
				end
				S_PICK: begin
					if (next_pid != '0) begin
						ticks_q <= quantum;
					end
					cur_q   <= next_pid;
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy                = (state_q != S_IDLE);
	assign fin                 = (state_q == S_DONE);
	assign fin_res.running_pid = cur_q;
	assign fin_res.switched    = (cur_q != before_q);
	assign fin_res.new_pid     = new_pid_q;
	assign fin_res.status      = status_q;

`ifndef SYNTHESIS
	a_pick_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && !qstat.empty) |-> qctrl.pop)
		else $error("Yield did not take the queue head.");
`endif

endmodule

/* test/rrps_sched_checker.sv */
// Scheduler checker: predicts each accepted request and compares the results that come back.
module rrps_sched_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  rrps_pkg::req_t                 req,
	input  logic                           cfg_we,
	input  logic [rrps_pkg::QUANTUM_W-1:0] cfg_wdata,
	input  logic                           done,
	input  rrps_pkg::result_t              result,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rrps_pkg::*;

	slot_st_t             slot_st [1:MAX_PROCS];
	pid_t                 ready_ring [MAX_PROCS];
	int                   ring_head;
	int                   ring_count;
	bit                   in_ring [1:MAX_PROCS];
	pid_t                 cur_pid;
	logic [QUANTUM_W-1:0] ticks_rem;
	logic [QUANTUM_W-1:0] quantum;
	result_t              expected_results [$];

	function automatic bit is_ready(pid_t id);
		return id != 0 && id <= MAX_PROCS && slot_st[id] == SLOT_RUNNABLE;
	endfunction

	function automatic void push_ready(pid_t id);
		if (id == 0 || id > MAX_PROCS) return;
		if (in_ring[id] || ring_count >= MAX_PROCS) return;
		ready_ring[(ring_head + ring_count) % MAX_PROCS] = id;
		ring_count++;
		in_ring[id] = 1'b1;
	endfunction

	function automatic void switch_process();
		pid_t prev;
		pid_t nxt;
		prev = cur_pid;
		if (ring_count > 0) begin
			nxt = ready_ring[ring_head];
			ring_head = (ring_head + 1) % MAX_PROCS;
			ring_count--;
			if (nxt != 0 && nxt <= MAX_PROCS) in_ring[nxt] = 1'b0;
		end else if (is_ready(prev)) begin
			nxt = prev;
		end else begin
			nxt = '0;
		end
		if (nxt != 0) ticks_rem = quantum;
		if (nxt != prev) begin
			if (is_ready(prev)) push_ready(prev);
			cur_pid = nxt;
		end
	endfunction

	function automatic result_t schedule_request(req_t r);
		result_t res;
		pid_t    prior;
		pid_t    given;
		pid_t    tgt;
		prior = cur_pid;
		given = '0;
		tgt = r.target_pid;
		res.status = STATUS_OK;
		case (r.req_type)
			REQ_CREATE: begin
				res.status = STATUS_NO_SLOT;
				for (int i = 1; i <= MAX_PROCS; i++) begin
					if (slot_st[i] == SLOT_UNUSED) begin
						slot_st[i] = SLOT_RUNNABLE;
						given = pid_t'(i);
						push_ready(given);
						res.status = STATUS_OK;
						break;
					end
				end
			end
			REQ_BLOCK, REQ_RESUME: begin
				if (tgt == 0 || tgt > MAX_PROCS || slot_st[tgt] == SLOT_UNUSED) begin
					res.status = STATUS_BAD_PID;
				end else if (r.req_type == REQ_BLOCK) begin
					slot_st[tgt] = SLOT_BLOCKED;
				end else begin
					slot_st[tgt] = SLOT_RUNNABLE;
					push_ready(tgt);
				end
			end
			REQ_TICK: begin
				if (cur_pid != 0) begin
					if (ticks_rem <= 1) begin
						ticks_rem = quantum;
						switch_process();
					end else begin
						ticks_rem--;
					end
				end
			end
			REQ_YIELD: begin
				switch_process();
			end
			default: ;
		endcase
		res.running_pid = cur_pid;
		res.switched = cur_pid != prior;
		res.new_pid = given;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 1; i <= MAX_PROCS; i++) begin
				slot_st[i] = SLOT_UNUSED;
				in_ring[i] = 1'b0;
			end
			for (int i = 0; i < MAX_PROCS; i++) ready_ring[i] = '0;
			ring_head = 0;
			ring_count = 0;
			cur_pid = '0;
			ticks_rem = '0;
			quantum = QUANTUM_RST;
			expected_results.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) quantum = cfg_wdata;
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request waiting: running_pid=%0d switched=%0d",
						$time, result.running_pid, result.switched,
						" new_pid=%0d status=%0d", result.new_pid, result.status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.running_pid !== want.running_pid ||
						result.switched !== want.switched ||
						result.new_pid !== want.new_pid ||
						result.status !== want.status) begin
						$display("%0t: mismatch: expected running_pid=%0d switched=%0d",
							$time, want.running_pid, want.switched,
							" new_pid=%0d status=%0d", want.new_pid, want.status);
						$display("%0t:           actual running_pid=%0d switched=%0d",
							$time, result.running_pid, result.switched,
							" new_pid=%0d status=%0d", result.new_pid, result.status);
						errors++;
					end
				end
			end
			if (start && !busy) expected_results.push_back(schedule_request(req));
			pending <= expected_results.size();
		end
	end

endmodule

/* test/tb_round_robin_process_scheduler.sv */
// Testbench top for the round-robin process scheduler: clock, reset, request stimulus and verdict.
module tb_round_robin_process_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import rrps_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 197;
	localparam logic [2:0] REQ_RSVD = 3'd5;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	req_t                 req = '0;
	logic                 cfg_we = 1'b0;
	logic [QUANTUM_W-1:0] cfg_wdata = '0;
	logic                 busy;
	logic                 done;
	result_t              result;
	int                   errors;
	int                   pending;
	int                   quiet_cycles = 0;
	bit                   no_gaps = 1'b0;

	always #5 clk = ~clk;

	round_robin_process_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	rrps_sched_checker sched_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic issue(logic [2:0] kind, pid_t target);
		int pick;
		int gap;
		start <= 1'b1;
		req <= '{req_type: kind, target_pid: target};
		do @(posedge clk); while (busy);
		pick = $urandom_range(0, 99);
		gap = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
		if (!no_gaps && gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_quantum(logic [QUANTUM_W-1:0] q);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [QUANTUM_W-1:0] plan [PHASES];
		logic [2:0]           kind;
		pid_t                 target;
		int                   pick;
		// A zero entry in the plan stands for a random quantum.
		plan = '{8'd1, 8'd255, 8'd2, 8'd3, 8'd0, 8'd1, 8'd10, 8'd0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_quantum(8'd2);
		issue(REQ_TICK, 4'd0);
		issue(REQ_YIELD, 4'd0);
		issue(REQ_BLOCK, 4'd1);
		issue(REQ_RESUME, 4'd0);
		issue(REQ_RESUME, 4'd15);
		issue(REQ_RSVD, 4'd3);
		issue(REQ_RSVD + 3'd2, 4'd9);
		issue(REQ_CREATE, 4'd0);
		issue(REQ_CREATE, 4'd5);
		issue(REQ_YIELD, 4'd0);
		issue(REQ_RESUME, 4'd1);
		issue(REQ_RESUME, 4'd2);
		issue(REQ_TICK, 4'd0);
		issue(REQ_TICK, 4'd0);
		issue(REQ_BLOCK, 4'd2);
		issue(REQ_YIELD, 4'd0);
		issue(REQ_BLOCK, 4'd1);
		issue(REQ_YIELD, 4'd0);
		repeat (MAX_PROCS - 1) issue(REQ_CREATE, 4'd15);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_quantum(plan[ph] != 0 ? plan[ph] : QUANTUM_W'($urandom_range(1, 255)));
			no_gaps = (ph == 2 || ph == 5);
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) kind = REQ_CREATE;
				else if (pick < 20) kind = REQ_BLOCK;
				else if (pick < 36) kind = REQ_RESUME;
				else if (pick < 76) kind = REQ_TICK;
				else if (pick < 94) kind = REQ_YIELD;
				else kind = REQ_RSVD + 3'($urandom_range(0, 2));
				if ($urandom_range(0, 99) < 85) target = pid_t'($urandom_range(1, MAX_PROCS));
				else target = pid_t'($urandom_range(0, 15));
				issue(kind, target);
			end
		end

		no_gaps = 1'b0;
		quiesce();
		repeat (12) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
